>>> hw/rtl/pbn_pkg.sv
// shared types, constants and state codes for the boolean network step block
// no dependencies
package pbn_pkg;

  localparam int MaxNodes   = 64;
  localparam int MaxFanin   = 8;
  localparam int FaninDepth = 512;
  localparam int TableDepth = 4096;
  localparam int ProbBits   = 16;

  localparam logic [2:0] OP_STEP  = 3'd0;
  localparam logic [2:0] OP_WBIT  = 3'd1;
  localparam logic [2:0] OP_RBIT  = 3'd2;
  localparam logic [2:0] OP_WFAN  = 3'd3;
  localparam logic [2:0] OP_WTAB  = 3'd4;
  localparam logic [2:0] OP_WPAR  = 3'd5;

  localparam logic [3:0] PS_START = 4'd0;
  localparam logic [3:0] PS_COUNT = 4'd1;
  localparam logic [3:0] PS_BASE  = 4'd2;
  localparam logic [3:0] PS_FIXED = 4'd3;
  localparam logic [3:0] PS_P00   = 4'd4;
  localparam logic [3:0] PS_P01   = 4'd5;
  localparam logic [3:0] PS_P10   = 4'd6;
  localparam logic [3:0] PS_P11   = 4'd7;
  localparam logic [3:0] PS_CUM   = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [1:0] FM_FREE  = 2'd0;
  localparam logic [1:0] FM_ZERO  = 2'd1;
  localparam logic [1:0] FM_ONE   = 2'd2;
  localparam logic [1:0] FM_HOLD  = 2'd3;

  localparam logic [1:0] REG_COUNT    = 2'd0;
  localparam logic [1:0] REG_WEIGHTED = 2'd1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  node_index;
    logic [3:0]  param_select;
    logic [11:0] slot;
    logic [16:0] value;
    logic [15:0] select_random;
    logic [15:0] flip_random;
  } in_item_t;

  typedef struct packed {
    logic [5:0] updated_node;
    logic       new_bit;
    logic       read_bit;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_USEL, S_WSRCH, S_WREAD, S_NODE, S_FANRD,
    S_FANBIT, S_TABRD, S_TABUSE, S_FLIP, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start_write;
    logic usel_mul;
    logic usel_take;
    logic srch_first;
    logic srch_next;
    logic srch_take;
    logic node_rd;
    logic fan_rd;
    logic fan_bit;
    logic tab_rd;
    logic tab_use;
    logic flip;
    logic no_node;
  } cmd_t;

  typedef struct packed {
    logic is_step;
    logic weighted;
    logic srch_hit;
    logic srch_end;
    logic fan_more;
    logic need_table;
    logic need_flip;
  } sts_t;

endpackage

>>> hw/rtl/pbn_datapath.sv
// datapath: node state, fan-in and table memories, parameter stores, selection
// depends on pbn_pkg
module pbn_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pbn_pkg::in_item_t in_item,
  input  logic [6:0]        node_count,
  input  logic              weighted_select,
  input  pbn_pkg::cmd_t     cmd,
  output pbn_pkg::sts_t     sts,
  output pbn_pkg::out_item_t result
);
  import pbn_pkg::*;

  logic [MaxNodes-1:0] node_bits;
  logic [1:0]          fixed_mode [MaxNodes];
  logic [6:0]          fanin_list [FaninDepth];
  logic [1:0]          truth_table [TableDepth];
  logic [8:0]          input_start [MaxNodes];
  logic [3:0]          input_count [MaxNodes];
  logic [11:0]         table_base [MaxNodes];
  logic [16:0]         keep_p00 [MaxNodes];
  logic [16:0]         keep_p01 [MaxNodes];
  logic [16:0]         keep_p10 [MaxNodes];
  logic [16:0]         keep_p11 [MaxNodes];
  logic [16:0]         cum_thr [MaxNodes+1];

  in_item_t    item;
  logic [6:0]  cnt;
  logic [22:0] prod;
  logic [6:0]  sidx;
  logic [16:0] thr_lo;
  logic [16:0] thr_hi;
  logic [5:0]  n;
  logic        old;
  logic [1:0]  mode;
  logic [8:0]  fstart;
  logic [3:0]  fcnt;
  logic [11:0] tbase;
  logic [16:0] k00, k01, k10, k11;
  logic [3:0]  j;
  logic [6:0]  fan_e;
  logic [7:0]  dec;
  logic [1:0]  tval;
  logic        tgt;
  logic [16:0] keep;
  logic        nb;
  logic [16:0] r1;
  logic [1:0]  st;

  always_comb begin
    cnt = node_count;
    if (node_count == 7'd0) cnt = 7'd1;
    if (node_count > 7'(MaxNodes)) cnt = 7'(MaxNodes);
  end

  assign r1 = {1'b0, item.select_random} + 17'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
    end
    if (cmd.usel_mul) begin
      prod <= 23'(item.select_random) * 23'(cnt);
    end
    if (cmd.srch_first) begin
      sidx <= 7'd0;
    end else if (cmd.srch_next) begin
      sidx <= sidx + 7'd1;
    end
    if (cmd.srch_next) begin
      thr_lo <= cum_thr[sidx];
      thr_hi <= cum_thr[sidx + 7'd1];
    end
    if (cmd.usel_take) begin
      n <= (prod[22:16] >= cnt) ? 6'(cnt - 7'd1) : prod[21:16];
    end else if (cmd.srch_take) begin
      n <= sidx[5:0] - 6'd1;
    end
    if (cmd.node_rd) begin
      old    <= node_bits[n];
      mode   <= fixed_mode[n];
      fstart <= input_start[n];
      fcnt   <= (input_count[n] > 4'(MaxFanin)) ? 4'(MaxFanin) : input_count[n];
      tbase  <= table_base[n];
      k00    <= keep_p00[n];
      k01    <= keep_p01[n];
      k10    <= keep_p10[n];
      k11    <= keep_p11[n];
      j      <= 4'd0;
      dec    <= 8'd0;
    end
    if (cmd.fan_rd) begin
      fan_e <= fanin_list[fstart + 9'(j)];
    end
    if (cmd.fan_bit) begin
      dec <= {dec[6:0], (fan_e != 7'd0) && (fan_e <= 7'(MaxNodes)) &&
             node_bits[6'(fan_e - 7'd1)]};
      j   <= j + 4'd1;
    end
    if (cmd.tab_rd) begin
      tval <= truth_table[tbase + 12'(dec)];
    end
  end

  always_comb begin
    tgt  = tval[0];
    keep = old ? (tval[0] ? k11 : k10) : (tval[0] ? k01 : k00);
    if (mode == FM_ZERO) begin
      tgt = 1'b0; keep = k00;
    end else if (mode == FM_ONE) begin
      tgt = 1'b1; keep = k11;
    end
    nb = sts.need_flip ? (({1'b0, item.flip_random} + 17'd1 > keep) ? ~tgt : tgt) : old;
  end

  assign sts.is_step    = item.opcode == OP_STEP;
  assign sts.weighted   = weighted_select;
  // registered thresholds belong to entry sidx-1
  assign sts.srch_hit   = thr_lo < r1 && thr_hi >= r1;
  assign sts.srch_end   = sidx >= cnt;
  assign sts.fan_more   = j < fcnt;
  assign sts.need_table = mode == FM_FREE;
  assign sts.need_flip  = (mode == FM_FREE) ? !tval[1] : (mode != FM_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_bits <= '0;
      for (int i = 0; i < MaxNodes; i++) fixed_mode[i] <= FM_FREE;
    end else begin
      if (cmd.flip) node_bits[n] <= nb;
      if (cmd.start_write && item.opcode == OP_WBIT && item.node_index < 7'(MaxNodes))
        node_bits[item.node_index[5:0]] <= item.value[0];
      if (cmd.start_write && item.opcode == OP_WPAR && item.param_select == PS_FIXED &&
          item.node_index < 7'(MaxNodes))
        fixed_mode[item.node_index[5:0]] <= item.value[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_write) begin
      if (item.opcode == OP_WFAN && item.slot < 12'(FaninDepth))
        fanin_list[item.slot[8:0]] <= item.value[6:0];
      if (item.opcode == OP_WTAB)
        truth_table[item.slot] <= item.value[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_write && item.opcode == OP_WPAR) begin
      if (item.param_select == PS_CUM && item.node_index <= 7'(MaxNodes))
        cum_thr[item.node_index] <= item.value;
      if (item.node_index < 7'(MaxNodes)) begin
        case (item.param_select)
          PS_START: input_start[item.node_index[5:0]] <= item.value[8:0];
          PS_COUNT: input_count[item.node_index[5:0]] <= item.value[3:0];
          PS_BASE:  table_base[item.node_index[5:0]]  <= item.value[11:0];
          PS_P00:   keep_p00[item.node_index[5:0]]    <= item.value;
          PS_P01:   keep_p01[item.node_index[5:0]]    <= item.value;
          PS_P10:   keep_p10[item.node_index[5:0]]    <= item.value;
          PS_P11:   keep_p11[item.node_index[5:0]]    <= item.value;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    st = ST_OK;
    case (item.opcode)
      OP_STEP: st = ST_OK;
      OP_WBIT, OP_RBIT: if (item.node_index >= 7'(MaxNodes)) st = ST_BAD;
      OP_WFAN: if (item.slot >= 12'(FaninDepth)) st = ST_BAD;
      OP_WTAB: st = ST_OK;
      OP_WPAR: begin
        if (item.param_select == PS_CUM) begin
          if (item.node_index > 7'(MaxNodes)) st = ST_BAD;
        end else if (item.param_select > PS_CUM || item.node_index >= 7'(MaxNodes)) begin
          st = ST_BAD;
        end
      end
      default: st = ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start_write) begin
      result.updated_node <= item.node_index[5:0];
      result.new_bit      <= (item.opcode == OP_WBIT && st == ST_OK) ? item.value[0] : 1'b0;
      result.read_bit     <= (item.opcode == OP_RBIT && st == ST_OK) ?
                             node_bits[item.node_index[5:0]] : 1'b0;
      result.status       <= st;
    end else if (cmd.no_node) begin
      result <= '{updated_node: 6'd0, new_bit: 1'b0, read_bit: 1'b0, status: ST_NONE};
    end else if (cmd.flip) begin
      result <= '{updated_node: n, new_bit: nb, read_bit: 1'b0, status: ST_OK};
    end
  end
endmodule

>>> hw/rtl/pbn_control.sv
// controller state machine sequencing one item through the datapath
// depends on pbn_pkg
module pbn_control (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pbn_pkg::sts_t  sts,
  output pbn_pkg::cmd_t  cmd
);
  import pbn_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_step) begin
          cmd.start_write = 1'b1;
          state_next      = S_DONE;
        end else if (sts.weighted) begin
          cmd.srch_first = 1'b1;
          state_next     = S_WREAD;
        end else begin
          cmd.usel_mul = 1'b1;
          state_next   = S_USEL;
        end
      end
      S_USEL: begin
        cmd.usel_take = 1'b1;
        state_next    = S_NODE;
      end
      S_WREAD: begin
        cmd.srch_next = 1'b1;
        state_next    = S_WSRCH;
      end
      S_WSRCH: begin
        if (sts.srch_hit) begin
          cmd.srch_take = 1'b1;
          state_next    = S_NODE;
        end else if (sts.srch_end) begin
          cmd.no_node = 1'b1;
          state_next  = S_DONE;
        end else begin
          state_next = S_WREAD;
        end
      end
      S_NODE: begin
        cmd.node_rd = 1'b1;
        state_next  = S_FANRD;
      end
      S_FANRD: begin
        if (!sts.need_table) begin
          state_next = S_TABUSE;
        end else if (sts.fan_more) begin
          cmd.fan_rd = 1'b1;
          state_next = S_FANBIT;
        end else begin
          cmd.tab_rd = 1'b1;
          state_next = S_TABUSE;
        end
      end
      S_FANBIT: begin
        cmd.fan_bit = 1'b1;
        state_next  = S_FANRD;
      end
      S_TABUSE: begin
        state_next = S_FLIP;
      end
      S_FLIP: begin
        cmd.flip   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !out_valid || out_ready) else $error("result overrun");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid) else $error("result lost");
endmodule

>>> hw/rtl/async_prob_boolean_net_step_top.sv
// top level of the probabilistic boolean network step block
// depends on pbn_pkg, pbn_control, pbn_datapath
// writes and reads are decoded, then finish; a step picks a node, walks its fan-in,
// reads the table if the node is free and updates its bit; a weighted pick searches
// up to 64 thresholds, may find none; one item at a time; reset is synchronous and
// clears node bits, fixed modes, weighting, fsm; sets node count 1; rest undefined
module async_prob_boolean_net_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbn_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pbn_pkg::*;

  logic [6:0] node_count;
  logic       weighted_select;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 7'd1;
      weighted_select <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_COUNT[0]:    node_count      <= pwdata[6:0];
        REG_WEIGHTED[0]: weighted_select <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COUNT[0]: prdata = {25'd0, node_count};
      default:      prdata = {31'd0, weighted_select};
    endcase
  end

  pbn_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  pbn_datapath u_dp (
    .clk, .rst, .in_item(in_data), .node_count, .weighted_select, .cmd, .sts,
    .result(out_data)
  );
endmodule
